### rtl/cpb_pkg.sv
// ---------------------------------------------------------------------------
// cpb_pkg: shared types, constants and tables for the colour blender
// Holds the xterm-256 palette expansion table, the blend and quantiser
// constants, and the payload types of the pipeline stages.
// ---------------------------------------------------------------------------
package cpb_pkg;

	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int RATIO_W = 7;
	// ratio*a + (100-ratio)*b peaks at 25500, which fits in 15 bits.
	localparam int SUM_W   = 15;
	// Reciprocal of 100 scaled by 2^19; exact for every sum up to 25500.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = RECIP_SHIFT + CHAN_W;

	localparam logic [RATIO_W-1:0] RATIO_FULL = 7'd100;
	localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;
	localparam logic [7:0]         CUBE_BASE  = 8'd16;
	localparam logic [7:0]         CUBE_ROW   = 8'd36;
	localparam logic [7:0]         CUBE_COL   = 8'd6;
	localparam logic [2:0]         CUBE_STEPS = 3'd6;

	// Palette modes carried in the op field.
	localparam logic OP_RGB     = 1'b0;
	localparam logic OP_PALETTE = 1'b1;

	typedef logic [COLOR_W-1:0] pal_tab_t [256];

	localparam logic [CHAN_W-1:0] CUBE_LEVEL [6] = '{
		8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF
	};

	localparam logic [COLOR_W-1:0] ANSI_RGB [16] = '{
		24'h000000, 24'hE00000, 24'h00E000, 24'hE0E000,
		24'h0000E0, 24'hE000E0, 24'h00E0E0, 24'hE0E0E0,
		24'h808080, 24'hFF4040, 24'h40FF40, 24'hFFFF40,
		24'h4040FF, 24'hFF40FF, 24'h40FFFF, 24'hFFFFFF
	};

	// Builds the full index-to-RGB table at elaboration.
	function automatic pal_tab_t build_pal_tab();
		pal_tab_t          tab;
		int                k;
		logic [CHAN_W-1:0] grey;
		for (int n = 0; n < 256; n++) begin
			if (n < 16) begin
				tab[n] = ANSI_RGB[n];
			end else if (n < 232) begin
				k = n - 16;
				tab[n] = {CUBE_LEVEL[(k / 36) % 6], CUBE_LEVEL[(k / 6) % 6],
					CUBE_LEVEL[k % 6]};
			end else begin
				grey = CHAN_W'(8 + 10 * (n - 232));
				tab[n] = {grey, grey, grey};
			end
		end
		return tab;
	endfunction

	localparam pal_tab_t PAL_RGB = build_pal_tab();

	// Stage 1: saturated ratio and both colours in RGB form.
	typedef struct packed {
		logic               op;
		logic [RATIO_W-1:0] ratio;
		logic [COLOR_W-1:0] rgb_a;
		logic [COLOR_W-1:0] rgb_b;
	} stage1_t;

	// Stage 2: weighted sums, one per channel (index 2 is red).
	typedef struct packed {
		logic                      op;
		logic [2:0][SUM_W-1:0]     sum;
	} stage2_t;

	// Stage 3: sums scaled by the reciprocal of 100.
	typedef struct packed {
		logic                      op;
		logic [2:0][PROD_W-1:0]    prod;
	} stage3_t;

endpackage

### rtl/cpb_expand.sv
// ---------------------------------------------------------------------------
// cpb_expand: ratio saturation and palette expansion
// Clamps the ratio to 100 and, in palette mode, looks up the RGB value of
// both palette indices, then registers the word into stage 1.
// ---------------------------------------------------------------------------
module cpb_expand (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en_s1,
	input  logic                         in_valid,
	input  logic                         op,
	input  logic [cpb_pkg::RATIO_W-1:0]  ratio,
	input  logic [cpb_pkg::COLOR_W-1:0]  color_a,
	input  logic [cpb_pkg::COLOR_W-1:0]  color_b,
	output logic                         valid_s1,
	output cpb_pkg::stage1_t             data_s1
);

	cpb_pkg::stage1_t next_s1;

	// Saturate the ratio and select the RGB form of each colour.
	always_comb begin
		next_s1.op    = op;
		next_s1.ratio = (ratio > cpb_pkg::RATIO_FULL) ? cpb_pkg::RATIO_FULL : ratio;
		if (op == cpb_pkg::OP_PALETTE) begin
			next_s1.rgb_a = cpb_pkg::PAL_RGB[color_a[7:0]];
			next_s1.rgb_b = cpb_pkg::PAL_RGB[color_b[7:0]];
		end else begin
			next_s1.rgb_a = color_a;
			next_s1.rgb_b = color_b;
		end
	end

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			data_s1 <= next_s1;
		end
	end

endmodule

### rtl/cpb_mix.sv
// ---------------------------------------------------------------------------
// cpb_mix: weighted sum and division by 100
// Stage 2 forms ratio*a + (100-ratio)*b per channel; stage 3 multiplies
// each sum by the scaled reciprocal of 100.
// ---------------------------------------------------------------------------
module cpb_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en_s2,
	input  logic              en_s3,
	input  logic              valid_s1,
	input  cpb_pkg::stage1_t  data_s1,
	output logic              valid_s2,
	output logic              valid_s3,
	output cpb_pkg::stage3_t  data_s3
);

	cpb_pkg::stage2_t data_s2;
	cpb_pkg::stage2_t next_s2;
	cpb_pkg::stage3_t next_s3;
	logic [cpb_pkg::RATIO_W-1:0] inv_ratio;

	// Weighted sum of each channel pair.
	always_comb begin
		inv_ratio   = cpb_pkg::RATIO_FULL - data_s1.ratio;
		next_s2.op  = data_s1.op;
		for (int c = 0; c < 3; c++) begin
			next_s2.sum[c] =
				cpb_pkg::SUM_W'({8'd0, data_s1.ratio} *
					{7'd0, data_s1.rgb_a[c*cpb_pkg::CHAN_W +: cpb_pkg::CHAN_W]}) +
				cpb_pkg::SUM_W'({8'd0, inv_ratio} *
					{7'd0, data_s1.rgb_b[c*cpb_pkg::CHAN_W +: cpb_pkg::CHAN_W]});
		end
	end

	// Scale by the reciprocal of 100; the shift follows in the next stage.
	always_comb begin
		next_s3.op = data_s2.op;
		for (int c = 0; c < 3; c++) begin
			next_s3.prod[c] = cpb_pkg::PROD_W'(
				{13'd0, data_s2.sum[c]} * {15'd0, cpb_pkg::RECIP_100});
		end
	end

	// Valid bits of stages 2 and 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Payload registers of stages 2 and 3.
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			data_s2 <= next_s2;
		end
		if (en_s3 && valid_s2) begin
			data_s3 <= next_s3;
		end
	end

endmodule

### rtl/cpb_quant.sv
// ---------------------------------------------------------------------------
// cpb_quant: channel extraction, cube quantiser and output register
// Takes the quotient of each channel and, in palette mode, maps the blended
// RGB value back to a 6x6x6 cube index.
// ---------------------------------------------------------------------------
module cpb_quant (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en_out,
	input  logic                         valid_s3,
	input  cpb_pkg::stage3_t             data_s3,
	output logic                         out_valid,
	output logic [cpb_pkg::COLOR_W-1:0]  blended
);

	logic [2:0][cpb_pkg::CHAN_W-1:0] chan;
	logic [2:0][2:0]                 level;
	logic [cpb_pkg::CHAN_W-1:0]      cube_idx;
	logic [cpb_pkg::COLOR_W-1:0]     next_out;
	logic                            op_q;

	// Quotient per channel, then its cube level as chan*6/256.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			chan[c]  = data_s3.prod[c][cpb_pkg::PROD_W-1:cpb_pkg::RECIP_SHIFT];
			level[c] = 3'(({3'd0, chan[c]} * {8'd0, cpb_pkg::CUBE_STEPS}) >> 8);
		end
		cube_idx = cpb_pkg::CUBE_BASE + 8'({5'd0, level[2]} * cpb_pkg::CUBE_ROW) +
			8'({5'd0, level[1]} * cpb_pkg::CUBE_COL) + {5'd0, level[0]};
		if (data_s3.op == cpb_pkg::OP_PALETTE) begin
			next_out = {16'd0, cube_idx};
		end else begin
			next_out = {chan[2], chan[1], chan[0]};
		end
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= valid_s3;
		end
	end

	// Output word.
	always_ff @(posedge clk) begin
		if (en_out && valid_s3) begin
			blended <= next_out;
			op_q    <= data_s3.op;
		end
	end

	// A palette result is always a cube index.
	a_palette_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && op_q == cpb_pkg::OP_PALETTE) |->
			(blended[23:8] == 16'd0 && blended[7:0] >= 8'd16 && blended[7:0] <= 8'd231))
		else $error("palette result outside the cube range");

endmodule

### rtl/color_percent_blend.sv
// ---------------------------------------------------------------------------
// color_percent_blend: percentage blend of two colours
// Blends two 24-bit RGB colours, or two xterm-256 palette indices mapped
// back to a cube index, by a weight in percent of the first colour.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------
//   input   | in_valid / in_stall  | op, ratio, color_a, color_b
//   output  | out_valid / out_stall| blended
//
// One word enters per cycle while in_stall is low; each word passes through the stages
// expand, weighted sum, reciprocal multiply, quantise and output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output holds its word, and the stages behind it fill any gaps
// before in_stall rises, so bubbles are squeezed out.
// ---------------------------------------------------------------------------
module color_percent_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [cpb_pkg::RATIO_W-1:0]  ratio,
	input  logic [cpb_pkg::COLOR_W-1:0]  color_a,
	input  logic [cpb_pkg::COLOR_W-1:0]  color_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cpb_pkg::COLOR_W-1:0]  blended
);

	logic             en_s1, en_s2, en_s3, en_out;
	logic             valid_s1, valid_s2, valid_s3;
	cpb_pkg::stage1_t data_s1;
	cpb_pkg::stage3_t data_s3;

	// A stage moves on when it is empty or the stage after it moves on.
	assign en_out   = !out_valid || !out_stall;
	assign en_s3    = !valid_s3 || en_out;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	cpb_expand u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s1    (en_s1),
		.in_valid (in_valid),
		.op       (op),
		.ratio    (ratio),
		.color_a  (color_a),
		.color_b  (color_b),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	cpb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s2    (en_s2),
		.en_s3    (en_s3),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	cpb_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.en_out    (en_out),
		.valid_s3  (valid_s3),
		.data_s3   (data_s3),
		.out_valid (out_valid),
		.blended   (blended)
	);

	// An accepted word lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted word lost at stage 1");

	// A held stage 3 word keeps its payload.
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_out) |=> (valid_s3 && $stable(data_s3)))
		else $error("stage 3 word changed while held");

	// The input is stalled only when every stage is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

### sim/color_percent_blend_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_percent_blend_tb: self-checking bench for the percentage colour blender
// Drives a short table of corner words and then random RGB and palette words.
// Each input word is modelled on acceptance, and each output word is compared
// in order with the oldest prediction. Traffic runs in several phases of
// sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module color_percent_blend_tb;

	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int RANDOM_PER_PHASE = 283;
	localparam int DRAIN_CYCLES     = 12;
	localparam int PERCENT          = 100;
	localparam int CUBE_OFFSET      = 16;
	localparam int GREY_FIRST       = 232;
	localparam int NUM_DIRECTED     = 18;

	// Sender gap and receiver stall chances, in percent, for each phase.
	localparam int PHASE_SEND_IDLE [4] = '{0, 78, 0, 15};
	localparam int PHASE_STALL     [4] = '{0, 0, 78, 15};

	localparam logic [cpb_pkg::COLOR_W-1:0] ANSI_COLOURS [16] = '{
		24'h000000, 24'hE00000, 24'h00E000, 24'hE0E000,
		24'h0000E0, 24'hE000E0, 24'h00E0E0, 24'hE0E0E0,
		24'h808080, 24'hFF4040, 24'h40FF40, 24'hFFFF40,
		24'h4040FF, 24'hFF40FF, 24'h40FFFF, 24'hFFFFFF
	};
	localparam logic [cpb_pkg::CHAN_W-1:0] CUBE_LEVELS [6] = '{
		8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF
	};

	typedef struct packed {
		logic                        op;
		logic [cpb_pkg::RATIO_W-1:0] ratio;
		logic [cpb_pkg::COLOR_W-1:0] col_a;
		logic [cpb_pkg::COLOR_W-1:0] col_b;
		logic                        known;
		logic [cpb_pkg::COLOR_W-1:0] value;
	} corner_row_t;

	// Corner words; known rows carry a result that can be read off directly.
	localparam corner_row_t CORNER_ROWS [NUM_DIRECTED] = '{
		'{cpb_pkg::OP_RGB,     7'd100, 24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFFFF},
		'{cpb_pkg::OP_RGB,     7'd0,   24'hFFFFFF, 24'h000000, 1'b1, 24'h000000},
		'{cpb_pkg::OP_RGB,     7'd127, 24'h123456, 24'hABCDEF, 1'b1, 24'h123456},
		'{cpb_pkg::OP_RGB,     7'd101, 24'hFF00FF, 24'h00FF00, 1'b1, 24'hFF00FF},
		'{cpb_pkg::OP_RGB,     7'd127, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{cpb_pkg::OP_RGB,     7'd0,   24'h000000, 24'h000000, 1'b1, 24'h000000},
		'{cpb_pkg::OP_RGB,     7'd50,  24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
		'{cpb_pkg::OP_RGB,     7'd1,   24'h000000, 24'hFFFFFF, 1'b0, 24'h000000},
		'{cpb_pkg::OP_RGB,     7'd99,  24'hFF8001, 24'h00FF7E, 1'b0, 24'h000000},
		'{cpb_pkg::OP_PALETTE, 7'd100, 24'h000000, 24'h0000FF, 1'b1, 24'h000010},
		'{cpb_pkg::OP_PALETTE, 7'd100, 24'h0000E7, 24'h000000, 1'b1, 24'h0000E7},
		'{cpb_pkg::OP_PALETTE, 7'd0,   24'h000000, 24'h00000F, 1'b1, 24'h0000E7},
		'{cpb_pkg::OP_PALETTE, 7'd127, 24'hABCD10, 24'hFFFFE7, 1'b1, 24'h000010},
		'{cpb_pkg::OP_PALETTE, 7'd50,  24'h0000E8, 24'h0000FF, 1'b0, 24'h000000},
		'{cpb_pkg::OP_PALETTE, 7'd37,  24'h000009, 24'h0000C4, 1'b0, 24'h000000},
		'{cpb_pkg::OP_PALETTE, 7'd0,   24'h5A5A5A, 24'hFFFF08, 1'b0, 24'h000000},
		'{cpb_pkg::OP_PALETTE, 7'd127, 24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
		'{cpb_pkg::OP_PALETTE, 7'd73,  24'h0000F3, 24'hFF00A5, 1'b0, 24'h000000}
	};

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic                        op        = cpb_pkg::OP_RGB;
	logic [cpb_pkg::RATIO_W-1:0] ratio     = '0;
	logic [cpb_pkg::COLOR_W-1:0] color_a   = '0;
	logic [cpb_pkg::COLOR_W-1:0] color_b   = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [cpb_pkg::COLOR_W-1:0] blended;

	// Known result for the word on the input, when the table gives one.
	logic                        word_known = 1'b0;
	logic [cpb_pkg::COLOR_W-1:0] word_value = '0;

	logic [cpb_pkg::COLOR_W-1:0] pending_blends [$];
	int                          error_count   = 0;
	int                          quiet_cycles  = 0;
	int                          send_idle_pct = 0;
	int                          stall_pct     = 0;

	color_percent_blend u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.ratio     (ratio),
		.color_a   (color_a),
		.color_b   (color_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.blended   (blended)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Weighted mix of two RGB words, channel by channel, truncated.
	function automatic logic [cpb_pkg::COLOR_W-1:0] mix_colours(int unsigned w,
			logic [cpb_pkg::COLOR_W-1:0] x, logic [cpb_pkg::COLOR_W-1:0] y);
		logic [cpb_pkg::COLOR_W-1:0] res;
		int unsigned                 xc;
		int unsigned                 yc;
		for (int ch = 0; ch < 3; ch++) begin
			xc = x[cpb_pkg::CHAN_W*ch +: cpb_pkg::CHAN_W];
			yc = y[cpb_pkg::CHAN_W*ch +: cpb_pkg::CHAN_W];
			res[cpb_pkg::CHAN_W*ch +: cpb_pkg::CHAN_W] =
				cpb_pkg::CHAN_W'((w * xc + (PERCENT - w) * yc) / PERCENT);
		end
		return res;
	endfunction

	// Expansion of a palette index to RGB: ANSI entries, cube, grey ramp.
	function automatic logic [cpb_pkg::COLOR_W-1:0] palette_rgb(logic [7:0] idx);
		int unsigned                k;
		logic [cpb_pkg::CHAN_W-1:0] grey;
		if (idx < CUBE_OFFSET) begin
			return ANSI_COLOURS[idx];
		end
		if (idx < GREY_FIRST) begin
			k = idx - CUBE_OFFSET;
			return {CUBE_LEVELS[k / 36], CUBE_LEVELS[(k / 6) % 6], CUBE_LEVELS[k % 6]};
		end
		grey = cpb_pkg::CHAN_W'(8 + 10 * (idx - GREY_FIRST));
		return {grey, grey, grey};
	endfunction

	// Expected blended word for one input word.
	function automatic logic [cpb_pkg::COLOR_W-1:0] predict_blend(logic op_i,
			logic [cpb_pkg::RATIO_W-1:0] ratio_i, logic [cpb_pkg::COLOR_W-1:0] a_i,
			logic [cpb_pkg::COLOR_W-1:0] b_i);
		int unsigned                 w;
		int unsigned                 r;
		int unsigned                 g;
		int unsigned                 bl;
		logic [cpb_pkg::COLOR_W-1:0] mix;
		w = (ratio_i > PERCENT) ? PERCENT : ratio_i;
		if (op_i == cpb_pkg::OP_RGB) begin
			return mix_colours(w, a_i, b_i);
		end
		mix = mix_colours(w, palette_rgb(a_i[7:0]), palette_rgb(b_i[7:0]));
		r   = mix[23:16];
		g   = mix[15:8];
		bl  = mix[7:0];
		return cpb_pkg::COLOR_W'(CUBE_OFFSET + 36 * (r * 6 / 256) + 6 * (g * 6 / 256) +
			bl * 6 / 256);
	endfunction

	// Offers one word after a random gap and holds it until it is taken.
	// Payload noise is driven during the gap, while valid is low.
	task automatic send_word(input logic op_i, input logic [cpb_pkg::RATIO_W-1:0] ratio_i,
			input logic [cpb_pkg::COLOR_W-1:0] a_i, input logic [cpb_pkg::COLOR_W-1:0] b_i,
			input logic known_i, input logic [cpb_pkg::COLOR_W-1:0] value_i);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			op       <= 1'($urandom_range(1));
			ratio    <= cpb_pkg::RATIO_W'($urandom);
			color_a  <= cpb_pkg::COLOR_W'($urandom);
			color_b  <= cpb_pkg::COLOR_W'($urandom);
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= op_i;
		ratio      <= ratio_i;
		color_a    <= a_i;
		color_b    <= b_i;
		word_known <= known_i;
		word_value <= value_i;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Random word: mostly in-range ratios, palette indices spread over all regions.
	task automatic send_random_word();
		logic                        op_r;
		logic [cpb_pkg::RATIO_W-1:0] ratio_r;
		logic [cpb_pkg::COLOR_W-1:0] a_r;
		logic [cpb_pkg::COLOR_W-1:0] b_r;
		op_r = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: begin
				ratio_r = '0;
			end
			1: begin
				ratio_r = cpb_pkg::RATIO_W'(PERCENT);
			end
			2, 3: begin
				ratio_r = cpb_pkg::RATIO_W'($urandom_range(127, PERCENT + 1));
			end
			default: begin
				ratio_r = cpb_pkg::RATIO_W'($urandom_range(PERCENT));
			end
		endcase
		a_r = cpb_pkg::COLOR_W'($urandom);
		b_r = cpb_pkg::COLOR_W'($urandom);
		if (op_r == cpb_pkg::OP_PALETTE && $urandom_range(1) == 0) begin
			a_r[7:0] = 8'($urandom_range(CUBE_OFFSET - 1));
			b_r[7:0] = 8'($urandom_range(255, GREY_FIRST));
		end
		send_word(op_r, ratio_r, a_r, b_r, 1'b0, '0);
	endtask

	// Receiver stall pattern, changed on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Record predictions on input acceptance; check words on output acceptance.
	always @(posedge clk) begin
		logic [cpb_pkg::COLOR_W-1:0] exp_word;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_blends.push_back(word_known ? word_value
					: predict_blend(op, ratio, color_a, color_b));
			end
			if (out_valid && !out_stall) begin
				if (pending_blends.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %06h", $time, blended);
					error_count++;
				end else begin
					exp_word = pending_blends.pop_front();
					if (blended !== exp_word) begin
						$display("%0t: blended mismatch, expected %06h, got %06h",
							$time, exp_word, blended);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, corner table, then random phases.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_word(CORNER_ROWS[i].op, CORNER_ROWS[i].ratio, CORNER_ROWS[i].col_a,
				CORNER_ROWS[i].col_b, CORNER_ROWS[i].known, CORNER_ROWS[i].value);
		end

		for (int ph = 0; ph < 4; ph++) begin
			// Each new phase starts only once every pending word has come out.
			if (ph != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending_blends.size() != 0) begin
					@(posedge clk);
				end
			end
			send_idle_pct = PHASE_SEND_IDLE[ph];
			stall_pct     = PHASE_STALL[ph];
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				send_random_word();
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_blends.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
